### hw/rtl/sme_pkg.sv
// Shared constants and types for the sliding min/max envelope.
`default_nettype none

package sme_pkg;

    // Default sample width; the top level may override it.
    localparam int SAMPLE_BITS_DEF = 16;
    // Widest half width, also chosen by a zero register value.
    localparam int MAX_WINDOW = 63;
    // Sequence length that the reported position wraps at.
    localparam int MAX_LEN = 4096;
    localparam int POS_W = $clog2(MAX_LEN);
    // Width of the half-width register.
    localparam int WIN_W = 6;
    // Position counters and expiry marks wrap at this width.
    localparam int CNT_W = 13;
    // Cells in each monotonic queue.
    localparam int QDEPTH = 128;
    // Most results a final sample may flush.
    localparam int MAX_OUT = 64;

    typedef logic [CNT_W-1:0] sme_cnt_t;
    typedef logic [WIN_W-1:0] sme_win_t;

    // Command from the sequencer to one queue.
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } sme_queue_cmd_t;

    // Command from a queue to each of its cells.
    typedef struct packed {
        logic push;
        logic shift;
        logic clear;
    } sme_cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/sme_cell.sv
// One cell of a monotonic queue: a value, its expiry mark and an occupied flag.
`default_nettype none

module sme_cell
    import sme_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter bit IS_MAX      = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sme_cell_ctl_t                 ctl,
    input  logic signed [SAMPLE_BITS-1:0] new_val,
    input  sme_cnt_t                      new_expiry,
    input  logic                          left_keep,
    input  logic                          right_occ,
    input  logic signed [SAMPLE_BITS-1:0] right_val,
    input  sme_cnt_t                      right_expiry,
    output logic                          occ,
    output logic signed [SAMPLE_BITS-1:0] val,
    output sme_cnt_t                      expiry,
    output logic                          keep
);

    logic                          occ_reg, occ_next;
    logic signed [SAMPLE_BITS-1:0] val_reg, val_next;
    sme_cnt_t                      expiry_reg, expiry_next;
    logic                          drop;

    // Drop this entry when the incoming word dominates it.
    assign drop = IS_MAX ? (val_reg <= new_val) : (val_reg >= new_val);
    assign keep = occ_reg && !drop;

    // Clear, hold, take the right cell or the new word after the last kept cell.
    always_comb begin
        occ_next    = occ_reg;
        val_next    = val_reg;
        expiry_next = expiry_reg;
        priority if (ctl.clear) begin
            occ_next = 1'b0;
        end else if (ctl.shift) begin
            occ_next    = right_occ;
            val_next    = right_val;
            expiry_next = right_expiry;
        end else if (ctl.push && !keep) begin
            occ_next = left_keep;
            if (left_keep) begin
                val_next    = new_val;
                expiry_next = new_expiry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        expiry_reg <= expiry_next;
    end

    assign occ    = occ_reg;
    assign val    = val_reg;
    assign expiry = expiry_reg;

endmodule

`default_nettype wire

### hw/rtl/sme_queue.sv
// Monotonic queue built as a row of cells, head in cell 0.
`default_nettype none

module sme_queue
    import sme_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter bit IS_MAX      = 1'b0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sme_queue_cmd_t                cmd,
    input  logic signed [SAMPLE_BITS-1:0] new_val,
    input  sme_cnt_t                      new_expiry,
    input  sme_cnt_t                      ref_pos,
    output logic signed [SAMPLE_BITS-1:0] head_val,
    output logic                          head_expired
);

    logic                          occ    [QDEPTH];
    logic signed [SAMPLE_BITS-1:0] val    [QDEPTH];
    sme_cnt_t                      expiry [QDEPTH];
    logic                          keep   [QDEPTH];
    logic                          full;
    sme_cell_ctl_t                 ctl;
    sme_cnt_t                      head_age;

    // A full queue with nothing dropped loses its head to make room.
    assign full = occ[QDEPTH-1] && keep[QDEPTH-1];

    always_comb begin
        ctl.push  = cmd.push && !full;
        ctl.shift = cmd.pop || (cmd.push && full);
        ctl.clear = cmd.clear;
    end

    for (genvar g = 0; g < QDEPTH; g++) begin : g_cell
        logic                          left_keep;
        logic                          right_occ;
        logic signed [SAMPLE_BITS-1:0] right_val;
        sme_cnt_t                      right_expiry;

        if (g == 0) begin : g_head
            assign left_keep = 1'b1;
        end else begin : g_body
            assign left_keep = keep[g-1];
        end

        // The tail cell shifts in the new word on a full push, else empties.
        if (g == QDEPTH - 1) begin : g_tail
            assign right_occ    = cmd.push;
            assign right_val    = new_val;
            assign right_expiry = new_expiry;
        end else begin : g_inner
            assign right_occ    = occ[g+1];
            assign right_val    = val[g+1];
            assign right_expiry = expiry[g+1];
        end

        sme_cell #(
            .SAMPLE_BITS(SAMPLE_BITS),
            .IS_MAX     (IS_MAX)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .new_val     (new_val),
            .new_expiry  (new_expiry),
            .left_keep   (left_keep),
            .right_occ   (right_occ),
            .right_val   (right_val),
            .right_expiry(right_expiry),
            .occ         (occ[g]),
            .val         (val[g]),
            .expiry      (expiry[g]),
            .keep        (keep[g])
        );
    end

    // Expire the head once the reference reaches its mark; never the newest entry.
    assign head_age     = ref_pos - expiry[0];
    assign head_expired = occ[1] && !head_age[CNT_W-1];
    assign head_val     = val[0];

endmodule

`default_nettype wire

### hw/rtl/sliding_min_max_envelope.sv
// Sliding-window min/max envelope, top level with sequencer and output register.
// Each sample word is pushed into a rising queue (minimum) and a falling queue
// (maximum), each a row of 128 cells that compare the new word in parallel in the
// accept cycle. A sample that yields a result is followed by removal of stale head
// entries (both queues drop their heads in the same cycle, one entry each per cycle)
// and then the result. The final sample of a sequence flushes up to 64 results,
// with stale heads removed as they expire; the queues and counters are then empty
// for the next sequence. Results wait in an output register: once the result of a
// non-final sample or the last flushed result is loaded the block takes samples
// again, and a stalled result channel holds it only when the next result is due
// while the register is still full. The user must write the window register only
// while idle; the block does not enforce this.
`default_nettype none

module sliding_min_max_envelope
    import sme_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample words
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic                          s_last_sample,
    // envelope words
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_lower,
    output logic signed [SAMPLE_BITS-1:0] m_upper,
    output logic [POS_W-1:0]              m_position,
    output logic                          m_last_output,
    // window register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [WIN_W-1:0]              cfg_window_half_width
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                          state_reg, state_next;
    sme_win_t                      win_reg;
    sme_cnt_t                      in_cnt_reg, in_cnt_next;
    sme_cnt_t                      out_cnt_reg, out_cnt_next;
    sme_cnt_t                      end_pos_reg, end_pos_next;
    logic                          flush_reg, flush_next;
    logic                          m_valid_reg, m_valid_next;
    logic signed [SAMPLE_BITS-1:0] lower_reg, upper_reg;
    logic [POS_W-1:0]              position_reg;
    logic                          last_reg;

    sme_win_t                      w;
    sme_cnt_t                      new_expiry;
    sme_cnt_t                      lag;
    sme_cnt_t                      ref_pos;
    logic                          accept;
    logic                          out_free;
    logic                          flush_end;
    logic                          do_emit;
    logic                          min_expired, max_expired;
    logic signed [SAMPLE_BITS-1:0] min_head, max_head;
    sme_queue_cmd_t                min_cmd, max_cmd;

    // Window register: always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (cfg_valid) begin
            win_reg <= cfg_window_half_width;
        end
    end

    // Effective half width: zero or oversize selects the widest band.
    assign w = ((win_reg == '0) || (win_reg > WIN_W'(MAX_WINDOW))) ?
               WIN_W'(MAX_WINDOW) : win_reg;

    assign accept     = s_valid && s_ready;
    assign new_expiry = in_cnt_reg + sme_cnt_t'({w, 1'b0}) + sme_cnt_t'(1);
    assign lag        = in_cnt_reg - out_cnt_reg;
    assign ref_pos    = out_cnt_reg + sme_cnt_t'(w);
    assign out_free   = !m_valid_reg || m_ready;
    assign flush_end  = flush_reg && (out_cnt_reg == end_pos_reg);
    assign do_emit    = (state_reg == ST_EMIT) && !min_expired && !max_expired && out_free;

    // Queues: push on accept, drop stale heads while emitting, clear at flush end.
    always_comb begin
        min_cmd.push  = accept;
        min_cmd.pop   = (state_reg == ST_EMIT) && min_expired;
        min_cmd.clear = do_emit && flush_end;
        max_cmd.push  = accept;
        max_cmd.pop   = (state_reg == ST_EMIT) && max_expired;
        max_cmd.clear = do_emit && flush_end;
    end

    sme_queue #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .IS_MAX     (1'b0)
    ) u_min_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (min_cmd),
        .new_val     (s_sample),
        .new_expiry  (new_expiry),
        .ref_pos     (ref_pos),
        .head_val    (min_head),
        .head_expired(min_expired)
    );

    sme_queue #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .IS_MAX     (1'b1)
    ) u_max_queue (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (max_cmd),
        .new_val     (s_sample),
        .new_expiry  (new_expiry),
        .ref_pos     (ref_pos),
        .head_val    (max_head),
        .head_expired(max_expired)
    );

    // Sequencer: accept a word, then emit one result if due or flush the sequence.
    always_comb begin
        state_next   = state_reg;
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        end_pos_next = end_pos_reg;
        flush_next   = flush_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (!s_last_sample) begin
                        in_cnt_next = in_cnt_reg + sme_cnt_t'(1);
                        if (lag >= sme_cnt_t'(w)) begin
                            flush_next = 1'b0;
                            state_next = ST_EMIT;
                        end
                    end else begin
                        in_cnt_next  = '0;
                        end_pos_next = in_cnt_reg;
                        flush_next   = 1'b1;
                        state_next   = ST_EMIT;
                        // Limit the flush to the newest positions.
                        if (lag >= sme_cnt_t'(MAX_OUT)) begin
                            out_cnt_next = in_cnt_reg - sme_cnt_t'(MAX_OUT - 1);
                        end
                    end
                end
            end
            ST_EMIT: begin
                if (do_emit) begin
                    out_cnt_next = out_cnt_reg + sme_cnt_t'(1);
                    if (!flush_reg) begin
                        state_next = ST_IDLE;
                    end else if (flush_end) begin
                        out_cnt_next = '0;
                        state_next   = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            in_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        end_pos_reg <= end_pos_next;
    end

    // Output register: load on emit, clear when taken.
    always_comb begin
        if (do_emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_emit) begin
            lower_reg    <= min_head;
            upper_reg    <= max_head;
            position_reg <= out_cnt_reg[POS_W-1:0];
            last_reg     <= flush_end;
        end
    end

    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_lower       = lower_reg;
    assign m_upper       = upper_reg;
    assign m_position    = position_reg;
    assign m_last_output = last_reg;

endmodule

`default_nettype wire

### hw/rtl/sme_chk.sv
// Port-level checks for the envelope block and the bind that attaches them.
`default_nettype none

module sme_chk
    import sme_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic signed [SAMPLE_BITS-1:0] m_lower,
    input logic signed [SAMPLE_BITS-1:0] m_upper,
    input logic [POS_W-1:0]              m_position,
    input logic                          m_last_output
);

    // Reset empties the result side.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // A new result word only comes out of a busy cycle.
    a_result_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result word appeared without busy cycle");

    // After the final result is loaded the block takes samples again.
    a_ready_after_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        ($rose(m_valid) && m_last_output) |-> s_ready)
        else $error("not ready after final result word");

    // A stalled result word holds.
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_lower) && $stable(m_upper)
                                   && $stable(m_position) && $stable(m_last_output)))
        else $error("stalled result word changed");

endmodule

bind sliding_min_max_envelope sme_chk #(
    .SAMPLE_BITS(SAMPLE_BITS)
) u_sme_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_lower      (m_lower),
    .m_upper      (m_upper),
    .m_position   (m_position),
    .m_last_output(m_last_output)
);

`default_nettype wire
